@@ rtl/chinese_numeral_to_binary_macros.svh @@
// Assertion macros used by the checker file of the numeral parser.
`ifndef CHINESE_NUMERAL_TO_BINARY_MACROS_SVH
`define CHINESE_NUMERAL_TO_BINARY_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CNB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("numeral parser check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CNB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("numeral parser check failed");

`endif

@@ rtl/cnb_pkg.sv @@
// Package with character codes, weights and shared types of the numeral parser.
`timescale 1ns / 1ps

package cnb_pkg;

	localparam int CODE_W = 16;
	localparam int DIGIT_W = 4;
	localparam int TENS_W = 7;
	localparam int HUND_W = 10;
	localparam int THOU_W = 14;
	localparam int SUM_W = 14;
	localparam int WAN_W = 27;
	localparam int MAG_W = 40;
	localparam int NUM_DIGITS = 10;

	localparam logic [CODE_W-1:0] CODE_TEN      = 16'hAC42;
	localparam logic [CODE_W-1:0] CODE_HUNDRED  = 16'hA8D5;
	localparam logic [CODE_W-1:0] CODE_THOUSAND = 16'hA561;
	localparam logic [CODE_W-1:0] CODE_WAN      = 16'hB855;
	localparam logic [CODE_W-1:0] CODE_YI       = 16'hBBF5;
	localparam logic [CODE_W-1:0] CODE_NEG      = 16'hAD74;

	localparam logic [CODE_W-1:0] DIGIT_CODES [NUM_DIGITS] = '{
		16'hB973, 16'hB3FC, 16'hB64C, 16'hB0D1, 16'hB876,
		16'hA5EE, 16'hB3B0, 16'hAC6D, 16'hAEC3, 16'hA868
	};

	localparam logic [TENS_W-1:0] TEN_WEIGHT = 7'd10;
	localparam logic [HUND_W-1:0] HUND_WEIGHT = 10'd100;
	localparam logic [THOU_W-1:0] THOU_WEIGHT = 14'd1000;
	localparam logic [WAN_W-1:0] WAN_WEIGHT = 27'd10000;
	localparam logic [MAG_W-1:0] YI_WEIGHT = 40'd100000000;

	typedef enum logic [2:0] {
		KIND_OTHER,
		KIND_DIGIT,
		KIND_TEN,
		KIND_HUNDRED,
		KIND_THOUSAND,
		KIND_WAN,
		KIND_YI,
		KIND_NEG
	} char_kind_t;

	typedef struct packed {
		char_kind_t kind;
		logic [DIGIT_W-1:0] digit;
	} char_info_t;

endpackage

@@ rtl/chinese_numeral_to_binary.sv @@
// Top level of the formal Chinese numeral parser with its stream ports.
`timescale 1ns / 1ps

// This block parses a formal Chinese numeral written in Big5 character codes,
// one character per request on the slave stream, and returns its sign and
// binary magnitude as one request on the master stream when the character
// flagged by tlast arrives. It takes one character every clock cycle while the
// input side is not stalled. A character first lands in an input register;
// from there it is decoded and folded into the digit, unit and group
// accumulators, and for the final character the sum is captured in the result
// register, from which the result is offered on the master stream. The input
// side stalls only while a finished result sits unclaimed in the result
// register and the next final character is waiting behind it in the input
// register; an ordinary character never holds up the input register. Codes
// that are not digits, units or the leading negative sign are ignored, and all
// state returns to its reset values after each result.
module chinese_numeral_to_binary
	import cnb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// Character stream.
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,   // [15:0] char_code
	input  logic             s_axis_tlast,   // last_char
	// Result stream.
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [39:0] magnitude
	output logic             m_axis_tuser    // [0] is_negative
);

	// Input register.
	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;
	logic              last_s1;

	// Result register.
	logic              out_valid_q;
	logic [MAG_W-1:0]  out_mag_q;
	logic              out_neg_q;

	char_info_t        info;
	logic              advance;
	logic              step;
	logic              is_negative;
	logic [MAG_W-1:0]  magnitude;

	// A held character may move on unless it is a final character and the
	// result register is still occupied by a result nobody has taken.
	assign advance = !last_s1 || !out_valid_q || m_axis_tready;
	assign step = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			code_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	cnb_decoder u_decoder (
		.char_code (code_s1),
		.info      (info)
	);

	cnb_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.last        (last_s1),
		.info        (info),
		.is_negative (is_negative),
		.magnitude   (magnitude)
	);

	// The result register fills from the final character of a numeral and
	// empties when the master side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_mag_q <= magnitude;
			out_neg_q <= is_negative;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_mag_q;
	assign m_axis_tuser = out_neg_q;

endmodule

@@ rtl/cnb_decoder.sv @@
// Character classifier: maps a Big5 code to its role and digit value.
`timescale 1ns / 1ps

module cnb_decoder
	import cnb_pkg::*;
(
	input  logic [CODE_W-1:0] char_code,
	output char_info_t        info
);

	logic                 hit;
	logic [DIGIT_W-1:0]   hit_digit;

	// The ten digit codes are distinct, so at most one compare matches.
	always_comb begin
		hit = 1'b0;
		hit_digit = '0;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (char_code == DIGIT_CODES[k]) begin
				hit = 1'b1;
				hit_digit = DIGIT_W'(k);
			end
		end
	end

	always_comb begin
		info.digit = hit_digit;
		if (hit) begin
			info.kind = KIND_DIGIT;
		end else begin
			case (char_code)
				CODE_TEN:      info.kind = KIND_TEN;
				CODE_HUNDRED:  info.kind = KIND_HUNDRED;
				CODE_THOUSAND: info.kind = KIND_THOUSAND;
				CODE_WAN:      info.kind = KIND_WAN;
				CODE_YI:       info.kind = KIND_YI;
				CODE_NEG:      info.kind = KIND_NEG;
				default:       info.kind = KIND_OTHER;
			endcase
		end
	end

endmodule

@@ rtl/cnb_accum.sv @@
// Parser state: digit, unit parts and group accumulators with their update logic.
`timescale 1ns / 1ps

module cnb_accum
	import cnb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             last,
	input  char_info_t       info,
	output logic             is_negative,
	output logic [MAG_W-1:0] magnitude
);

	logic [DIGIT_W-1:0] digit_q, digit_d;
	logic [TENS_W-1:0]  tens_q, tens_d;
	logic [HUND_W-1:0]  hund_q, hund_d;
	logic [THOU_W-1:0]  thou_q, thou_d;
	logic [WAN_W-1:0]   wan_q, wan_d;
	logic [MAG_W-1:0]   yi_q, yi_d;
	logic               sign_q, sign_d;
	logic               first_q;

	logic [SUM_W-1:0]   cur_sum;
	logic [SUM_W-1:0]   next_sum;

	// The group sum never exceeds 9999, so it fits the narrow width.
	assign cur_sum = SUM_W'(digit_q) + SUM_W'(tens_q) + SUM_W'(hund_q) + thou_q;

	always_comb begin
		digit_d = digit_q;
		tens_d = tens_q;
		hund_d = hund_q;
		thou_d = thou_q;
		wan_d = wan_q;
		yi_d = yi_q;
		sign_d = sign_q;
		case (info.kind)
			KIND_DIGIT: begin
				digit_d = info.digit;
			end
			KIND_TEN: begin
				tens_d = TENS_W'(digit_q) * TEN_WEIGHT;
				digit_d = '0;
			end
			KIND_HUNDRED: begin
				hund_d = HUND_W'(digit_q) * HUND_WEIGHT;
				digit_d = '0;
			end
			KIND_THOUSAND: begin
				thou_d = THOU_W'(digit_q) * THOU_WEIGHT;
				digit_d = '0;
			end
			KIND_WAN: begin
				wan_d = WAN_W'(cur_sum) * WAN_WEIGHT;
				digit_d = '0;
				tens_d = '0;
				hund_d = '0;
				thou_d = '0;
			end
			KIND_YI: begin
				yi_d = MAG_W'(cur_sum) * YI_WEIGHT;
				digit_d = '0;
				tens_d = '0;
				hund_d = '0;
				thou_d = '0;
			end
			KIND_NEG: begin
				sign_d = sign_q | first_q;
			end
			default: begin
			end
		endcase
	end

	assign next_sum = SUM_W'(digit_d) + SUM_W'(tens_d) + SUM_W'(hund_d) + thou_d;
	assign magnitude = MAG_W'(next_sum) + MAG_W'(wan_d) + yi_d;
	assign is_negative = sign_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			tens_q <= '0;
			hund_q <= '0;
			thou_q <= '0;
			wan_q <= '0;
			yi_q <= '0;
			sign_q <= 1'b0;
			first_q <= 1'b1;
		end else if (step) begin
			if (last) begin
				digit_q <= '0;
				tens_q <= '0;
				hund_q <= '0;
				thou_q <= '0;
				wan_q <= '0;
				yi_q <= '0;
				sign_q <= 1'b0;
				first_q <= 1'b1;
			end else begin
				digit_q <= digit_d;
				tens_q <= tens_d;
				hund_q <= hund_d;
				thou_q <= thou_d;
				wan_q <= wan_d;
				yi_q <= yi_d;
				sign_q <= sign_d;
				first_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/cnb_checker.sv @@
// Port-level checker of the numeral parser and its bind to the top level.
`timescale 1ns / 1ps
`include "chinese_numeral_to_binary_macros.svh"

module cnb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic accept_last;
	logic in_stalled;

	assign accept_last = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign in_stalled = !s_axis_tready && s_axis_tvalid;

	// An unclaimed result holds its value.
	`CNB_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// The character side waits only behind an unclaimed result.
	`CNB_ASSERT_IMPL(a_stall_cause, !s_axis_tready,
		m_axis_tvalid && !m_axis_tready)
	// A result that appears on an idle output stems from a final character that
	// was accepted and then held in the input register.
	`CNB_ASSERT_IMPL(a_result_source, $rose(m_axis_tvalid), $past(accept_last, 2))
	// A stalled character is still offered unchanged in the next cycle, and the
	// result it waits behind is still there.
	`CNB_ASSERT_NEXT(a_stall_persists, in_stalled,
		s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast) && m_axis_tvalid)

endmodule

bind chinese_numeral_to_binary cnb_checker u_cnb_checker (.*);
